// ===== sv/assert_macros.svh =====
// assertion macros shared by the page table block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ptm_pkg.sv =====
// constants, types and helpers of the page table map and translate block
package ptm_pkg;

   // sizing
   localparam int TABLE_SLOTS          = 16;
   localparam int IDENTITY_LARGE_PAGES = 32;
   localparam int DIR_ADDR_W           = 10;
   localparam int PTE_IDX_W            = 10;
   localparam int TBL_ENTRIES          = 1024;
   localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int SLOT_CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam int TBL_ADDR_W = SLOT_W + PTE_IDX_W;
   localparam int SWEEP_LEN  = TABLE_SLOTS * TBL_ENTRIES;

   // operation codes
   localparam logic [1:0] OP_MAP       = 2'd0;
   localparam logic [1:0] OP_UNMAP     = 2'd1;
   localparam logic [1:0] OP_TRANSLATE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
   localparam logic [1:0] ST_LARGE      = 2'd2;
   localparam logic [1:0] ST_EXHAUSTED  = 2'd3;

   // entry flag bits
   localparam int F_PRESENT = 0;
   localparam int F_LARGE   = 7;
   localparam logic [11:0] PTE_PRESENT_MASK = 12'h001;
   localparam logic [31:0] DIR_TABLE_FLAGS  = 32'h0000_0003;
   localparam logic [21:0] DIR_LARGE_FLAGS  = 22'h00_0083;

   // memory port bundles driven by the walker
   typedef struct packed {
      logic                  we;
      logic [DIR_ADDR_W-1:0] waddr;
      logic [31:0]           wdata;
      logic                  re;
      logic [DIR_ADDR_W-1:0] raddr;
   } dir_port_type;

   typedef struct packed {
      logic                  we;
      logic [TBL_ADDR_W-1:0] waddr;
      logic [31:0]           wdata;
      logic                  re;
      logic [TBL_ADDR_W-1:0] raddr;
   } tbl_port_type;

   // clearing pass status
   typedef struct packed {
      logic                  busy;
      logic [TBL_ADDR_W-1:0] idx;
   } sweep_type;

   // directory contents after reset: identity large pages at the bottom
   function automatic logic [31:0] dir_reset_entry(input logic [DIR_ADDR_W-1:0] i);
      logic [31:0] entry;
      entry = 32'h0;
      if ({1'b0, i} < (DIR_ADDR_W + 1)'(IDENTITY_LARGE_PAGES)) begin
         entry = {i, DIR_LARGE_FLAGS};
      end
      return entry;
   endfunction

endpackage

// ===== sv/ptm_if.sv =====
// request and response channel interfaces
interface ptm_req_if ();
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] virt_addr;
   logic [31:0] phys_addr;
   logic [11:0] entry_flags;

   modport source (output valid, op, virt_addr, phys_addr, entry_flags, input ready);
   modport sink (input valid, op, virt_addr, phys_addr, entry_flags, output ready);
endinterface

interface ptm_rsp_if ();
   logic        valid;
   logic        ready;
   logic [31:0] phys_out;
   logic [1:0]  status;
   logic        tlb_invalidate;

   modport source (output valid, phys_out, status, tlb_invalidate, input ready);
   modport sink (input valid, phys_out, status, tlb_invalidate, output ready);
endinterface

// ===== sv/page_table_map_translate_core.sv =====
// Page table map and translate core. Keeps a two-level page directory (1024 entries, the
// first IDENTITY_LARGE_PAGES of them identity 4 MiB large pages after reset) and a store of
// TABLE_SLOTS page tables of 1024 entries, both in synchronous rams with registered read data.
// Each request word (map, unmap, translate or the unused op code) gives exactly one response word.
// A request reads the directory in the cycle it is accepted. Map, unmap, translate of a large
// page or of an absent entry, and the unused op code answer from the directory step S_DIR, while
// a translate through a page table adds the dependent table ram read in state S_TBL. One
// request is in flight at a time; the response register lets a finished word wait while the
// next request is accepted. After reset a clearing pass writes every table entry and the
// directory reset contents, one entry a cycle, with req_bus.ready held low.
module page_table_map_translate_core import ptm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ptm_req_if.sink    req_bus,
   ptm_rsp_if.source  rsp_bus
);

   sweep_type    sweep;
   dir_port_type dir_port;
   tbl_port_type tbl_port;
   logic [31:0]  dir_rdata;
   logic [31:0]  tbl_rdata;

   // clearing pass after reset
   ptm_init u_init (
      .clock (clock),
      .reset (reset),
      .sweep (sweep)
   );

   // request sequencer
   ptm_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .sweep     (sweep),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .dir_port  (dir_port),
      .dir_rdata (dir_rdata),
      .tbl_port  (tbl_port),
      .tbl_rdata (tbl_rdata)
   );

   // page directory
   ptm_ram #(
      .ADDR_W (DIR_ADDR_W),
      .DATA_W (32)
   ) u_dir_ram (
      .clock (clock),
      .we    (dir_port.we),
      .waddr (dir_port.waddr),
      .wdata (dir_port.wdata),
      .re    (dir_port.re),
      .raddr (dir_port.raddr),
      .rdata (dir_rdata)
   );

   // page table slots
   ptm_ram #(
      .ADDR_W (TBL_ADDR_W),
      .DATA_W (32)
   ) u_tbl_ram (
      .clock (clock),
      .we    (tbl_port.we),
      .waddr (tbl_port.waddr),
      .wdata (tbl_port.wdata),
      .re    (tbl_port.re),
      .raddr (tbl_port.raddr),
      .rdata (tbl_rdata)
   );

endmodule

// ===== sv/ptm_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module ptm_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/ptm_init.sv =====
// clearing pass counter that runs once after reset
module ptm_init import ptm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   output sweep_type sweep
);

   logic [TBL_ADDR_W-1:0] idx_ff, idx_in;
   logic                  busy_ff, busy_in;

   // step through every table entry, the directory rides along the first rows
   always_comb begin
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         if (idx_ff == TBL_ADDR_W'(SWEEP_LEN - 1)) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

   assign sweep.busy = busy_ff;
   assign sweep.idx  = idx_ff;

endmodule

// ===== sv/ptm_walk.sv =====
// request sequencer: directory read, table read or write-back, response word
`include "assert_macros.svh"
module ptm_walk import ptm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  sweep_type     sweep,
   ptm_req_if.sink       req_bus,
   ptm_rsp_if.source     rsp_bus,
   output dir_port_type  dir_port,
   input  logic [31:0]   dir_rdata,
   output tbl_port_type  tbl_port,
   input  logic [31:0]   tbl_rdata
);

   typedef enum logic [1:0] {S_IDLE, S_DIR, S_TBL} state_type;

   state_type             state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [31:0]           va_ff, va_in;
   logic [31:0]           pa_ff, pa_in;
   logic [11:0]           fl_ff, fl_in;
   logic [SLOT_CNT_W-1:0] next_free_ff, next_free_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           phys_ff, phys_in;
   logic [1:0]            status_ff, status_in;
   logic                  inval_ff, inval_in;

   logic                  accept;
   logic                  rsp_free;
   logic                  de_present;
   logic                  de_large;
   logic                  pool_empty;
   logic [SLOT_W-1:0]     cur_slot;
   logic [SLOT_W-1:0]     new_slot;
   logic [PTE_IDX_W-1:0]  ti;
   logic                  need_tbl;
   logic                  alloc;
   logic                  pte_we;
   logic [31:0]           pte_data;
   logic [31:0]           res_phys;
   logic [1:0]            res_status;
   logic                  res_inval;
   logic                  finish_dir;
   logic                  dir_we;

   // handshake and directory entry decode
   assign req_bus.ready = (state_ff == S_IDLE) && !sweep.busy;
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign de_present    = dir_rdata[F_PRESENT];
   assign de_large      = dir_rdata[F_LARGE];
   assign pool_empty    = next_free_ff >= SLOT_CNT_W'(TABLE_SLOTS);
   assign cur_slot      = dir_rdata[12 +: SLOT_W];
   assign new_slot      = next_free_ff[SLOT_W-1:0];
   assign ti            = va_ff[21:12];

   // per-operation decision once the directory entry is in
   always_comb begin
      res_phys   = 32'h0;
      res_status = ST_OK;
      res_inval  = 1'b0;
      need_tbl   = 1'b0;
      alloc      = 1'b0;
      pte_we     = 1'b0;
      pte_data   = 32'h0;
      unique case (op_ff)
         OP_MAP: begin
            if (de_large) begin
               res_status = ST_LARGE;
            end else if (!de_present && pool_empty) begin
               res_status = ST_EXHAUSTED;
            end else begin
               alloc     = !de_present;
               pte_we    = 1'b1;
               pte_data  = {pa_ff[31:12], fl_ff | PTE_PRESENT_MASK};
               res_inval = 1'b1;
            end
         end
         OP_UNMAP: begin
            if (!de_present) begin
               res_status = ST_NOT_MAPPED;
            end else if (de_large) begin
               res_status = ST_LARGE;
            end else begin
               pte_we    = 1'b1;
               res_inval = 1'b1;
            end
         end
         OP_TRANSLATE: begin
            if (!de_present) begin
               res_status = ST_NOT_MAPPED;
            end else if (de_large) begin
               res_phys = {dir_rdata[31:22], va_ff[21:0]};
            end else begin
               need_tbl = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign finish_dir = (state_ff == S_DIR) && !need_tbl && rsp_free;
   assign dir_we     = sweep.busy ? (sweep.idx[TBL_ADDR_W-1:DIR_ADDR_W] == '0)
                                  : (finish_dir && alloc);

   // directory port: read on accept, write for the sweep or a new table
   always_comb begin
      dir_port.re    = accept;
      dir_port.raddr = req_bus.virt_addr[31:22];
      dir_port.we    = dir_we;
      if (sweep.busy) begin
         dir_port.waddr = sweep.idx[DIR_ADDR_W-1:0];
         dir_port.wdata = dir_reset_entry(sweep.idx[DIR_ADDR_W-1:0]);
      end else begin
         dir_port.waddr = va_ff[31:22];
         dir_port.wdata = (32'(new_slot) << 12) | DIR_TABLE_FLAGS;
      end
   end

   // table port: read for a walk, write for map, unmap or the sweep
   always_comb begin
      tbl_port.re    = (state_ff == S_DIR) && need_tbl;
      tbl_port.raddr = {cur_slot, ti};
      if (sweep.busy) begin
         tbl_port.we    = 1'b1;
         tbl_port.waddr = sweep.idx;
         tbl_port.wdata = 32'h0;
      end else begin
         tbl_port.we    = finish_dir && pte_we;
         tbl_port.waddr = {alloc ? new_slot : cur_slot, ti};
         tbl_port.wdata = pte_data;
      end
   end

   // sequencer and response register next values
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      va_in        = va_ff;
      pa_in        = pa_ff;
      fl_in        = fl_ff;
      next_free_in = next_free_ff;
      rsp_valid_in = rsp_valid_ff;
      phys_in      = phys_ff;
      status_in    = status_ff;
      inval_in     = inval_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_bus.op;
               va_in    = req_bus.virt_addr;
               pa_in    = req_bus.phys_addr;
               fl_in    = req_bus.entry_flags;
               state_in = S_DIR;
            end
         end
         S_DIR: begin
            if (need_tbl) begin
               state_in = S_TBL;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               phys_in      = res_phys;
               status_in    = res_status;
               inval_in     = res_inval;
               if (alloc) begin
                  next_free_in = next_free_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_TBL: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               inval_in     = 1'b0;
               if (tbl_rdata[F_PRESENT]) begin
                  phys_in   = {tbl_rdata[31:12], va_ff[11:0]};
                  status_in = ST_OK;
               end else begin
                  phys_in   = 32'h0;
                  status_in = ST_NOT_MAPPED;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      va_ff     <= va_in;
      pa_ff     <= pa_in;
      fl_ff     <= fl_in;
      phys_ff   <= phys_in;
      status_ff <= status_in;
      inval_ff  <= inval_in;
   end

   // response word
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.phys_out       = phys_ff;
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.tlb_invalidate = inval_ff;

   `ASSERT_IMPLIES(a_no_req_in_sweep, clock, reset, sweep.busy, !req_bus.ready, "request taken during clearing pass")
   `ASSERT_NEXT(a_accept_reads_dir, clock, reset, accept, state_ff == S_DIR, "accepted word did not move to directory step")
   `ASSERT_IMPLIES(a_pool_bound, clock, reset, 1'b1, next_free_ff <= SLOT_CNT_W'(TABLE_SLOTS), "slot pool counter overran")
   `ASSERT_IMPLIES(a_alloc_only_absent, clock, reset, dir_we && !sweep.busy, op_ff == OP_MAP && !de_present, "directory written for a present entry")

endmodule

// ===== test/page_table_map_translate_core_tb.sv =====
// self-checking testbench for the page table map and translate core
`timescale 1ns / 100ps

module page_table_map_translate_core_tb import ptm_pkg::*;;

   localparam int RANDOM_ITEMS   = 1129;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 500;
   localparam int HOT_DIRS       = 24;
   localparam int DRAIN_CYCLES   = 20;
   localparam int DIR_ENTRIES_TB = 1024;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] virt_addr;
      logic [31:0] phys_addr;
      logic [11:0] entry_flags;
   } page_req_type;

   typedef struct packed {
      logic [31:0] phys_out;
      logic [1:0]  status;
      logic        tlb_invalidate;
   } page_rsp_type;

   logic clock;
   logic reset;

   ptm_req_if req_bus ();
   ptm_rsp_if rsp_bus ();

   page_table_map_translate_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow copy of the directory, the table slots and the bump pool
   logic [31:0] shadow_dir [DIR_ENTRIES_TB];
   logic [31:0] page_tables [TABLE_SLOTS * TBL_ENTRIES];
   int unsigned slots_used;

   page_req_type pending_reqs [$];
   page_rsp_type expected_results [$];
   page_req_type next_req;
   page_rsp_type got_rsp;
   page_rsp_type want_rsp;

   int error_count;
   int words_received;
   int burst_left;
   int idle_cycles;
   int hold_left;
   bit hold_done;
   int ready_mode;
   int mode_left;
   logic [7:0] stall_pattern;
   int cycle_count;
   logic [9:0] hot_dir [HOT_DIRS];

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // apply one request to the shadow state and return the word it should give
   function automatic page_rsp_type apply_page_request(input page_req_type req);
      logic [9:0]   dir_idx;
      logic [9:0]   pte_idx;
      logic [31:0]  dir_entry;
      logic [31:0]  pte;
      logic [19:0]  slot;
      int           tbl_idx;
      page_rsp_type rsp;
      dir_idx   = req.virt_addr[31:22];
      pte_idx   = req.virt_addr[21:12];
      dir_entry = shadow_dir[dir_idx];
      slot      = dir_entry[31:12];
      rsp       = '0;
      case (req.op)
         OP_MAP: begin
            if (dir_entry[F_LARGE]) begin
               rsp.status = ST_LARGE;
            end else if (!dir_entry[F_PRESENT] && slots_used >= TABLE_SLOTS) begin
               rsp.status = ST_EXHAUSTED;
            end else begin
               if (!dir_entry[F_PRESENT]) begin
                  slot = 20'(slots_used);
                  slots_used++;
                  for (int k = 0; k < TBL_ENTRIES; k++) begin
                     page_tables[int'(slot) * TBL_ENTRIES + k] = '0;
                  end
                  shadow_dir[dir_idx] = {slot, 12'h000} | DIR_TABLE_FLAGS;
               end
               if (slot < TABLE_SLOTS) begin
                  tbl_idx = int'(slot) * TBL_ENTRIES + int'(pte_idx);
                  page_tables[tbl_idx] = {req.phys_addr[31:12],
                                          req.entry_flags | PTE_PRESENT_MASK};
               end
               rsp.tlb_invalidate = 1'b1;
            end
         end
         OP_UNMAP: begin
            if (!dir_entry[F_PRESENT]) begin
               rsp.status = ST_NOT_MAPPED;
            end else if (dir_entry[F_LARGE]) begin
               rsp.status = ST_LARGE;
            end else begin
               if (slot < TABLE_SLOTS) begin
                  tbl_idx = int'(slot) * TBL_ENTRIES + int'(pte_idx);
                  page_tables[tbl_idx] = '0;
               end
               rsp.tlb_invalidate = 1'b1;
            end
         end
         OP_TRANSLATE: begin
            if (!dir_entry[F_PRESENT]) begin
               rsp.status = ST_NOT_MAPPED;
            end else if (dir_entry[F_LARGE]) begin
               rsp.phys_out = {dir_entry[31:22], req.virt_addr[21:0]};
            end else begin
               pte = '0;
               if (slot < TABLE_SLOTS) begin
                  tbl_idx = int'(slot) * TBL_ENTRIES + int'(pte_idx);
                  pte = page_tables[tbl_idx];
               end
               if (pte[F_PRESENT]) begin
                  rsp.phys_out = {pte[31:12], req.virt_addr[11:0]};
               end else begin
                  rsp.status = ST_NOT_MAPPED;
               end
            end
         end
         default: begin
            // unused op code leaves everything alone and answers all zero
         end
      endcase
      return rsp;
   endfunction

   task automatic add_req(input logic [1:0] op, input logic [31:0] va,
                          input logic [31:0] pa, input logic [11:0] fl);
      page_req_type req;
      req.op          = op;
      req.virt_addr   = va;
      req.phys_addr   = pa;
      req.entry_flags = fl;
      pending_reqs.push_back(req);
   endtask

   // random virtual address: mostly a few hot directories so tables fill and get reused
   function automatic logic [31:0] pick_virt_addr();
      int unsigned sel;
      logic [9:0]  dir_idx;
      logic [9:0]  pte_idx;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         return $urandom;
      end
      if (sel < 25) begin
         dir_idx = 10'($urandom_range(0, IDENTITY_LARGE_PAGES - 1));
      end else begin
         dir_idx = hot_dir[$urandom_range(0, HOT_DIRS - 1)];
      end
      if ($urandom_range(0, 7) == 0) begin
         pte_idx = 10'($urandom);
      end else begin
         pte_idx = 10'($urandom_range(0, 15));
      end
      return {dir_idx, pte_idx, 12'($urandom)};
   endfunction

   // shadow reset, stimulus and end of run
   initial begin
      int unsigned op_sel;
      logic [1:0] op;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.op        = OP_MAP;
      req_bus.virt_addr = '0;
      req_bus.phys_addr = '0;
      req_bus.entry_flags = '0;
      rsp_bus.ready     = 1'b0;
      error_count       = 0;
      slots_used        = 0;
      for (int i = 0; i < DIR_ENTRIES_TB; i++) begin
         shadow_dir[i] = (i < IDENTITY_LARGE_PAGES) ? {10'(i), DIR_LARGE_FLAGS} : 32'h0;
      end
      for (int i = 0; i < TABLE_SLOTS * TBL_ENTRIES; i++) begin
         page_tables[i] = '0;
      end
      for (int i = 0; i < HOT_DIRS; i++) begin
         hot_dir[i] = 10'($urandom_range(IDENTITY_LARGE_PAGES, 1023));
      end

      // directed: large pages, absent entries, first table, clear entries, unused op
      add_req(OP_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000);
      add_req(OP_TRANSLATE, 32'h07FF_FFFF, 32'h0, 12'h000);
      add_req(OP_TRANSLATE, 32'h0800_0000, 32'h0, 12'h000);
      add_req(OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 12'h000);
      add_req(OP_MAP,       32'h0012_3456, 32'h5555_5000, 12'h003);
      add_req(OP_UNMAP,     32'h07C0_0000, 32'h0, 12'h000);
      add_req(OP_UNMAP,     32'h0800_0000, 32'h0, 12'h000);
      add_req(OP_MAP,       32'h0800_0000, 32'hFFFF_FFFF, 12'hFFF);
      add_req(OP_TRANSLATE, 32'h0800_0ABC, 32'h0, 12'h000);
      add_req(OP_TRANSLATE, 32'h0800_1000, 32'h0, 12'h000);
      add_req(OP_MAP,       32'hFFFF_FFFF, 32'h0000_0000, 12'h000);
      add_req(OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 12'h000);
      add_req(OP_UNMAP,     32'h0800_0000, 32'h0, 12'h000);
      add_req(OP_UNMAP,     32'h0800_0000, 32'h0, 12'h000);
      add_req(OP_TRANSLATE, 32'h0800_0000, 32'h0, 12'h000);
      add_req(2'd3,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
      add_req(OP_MAP,       32'h0800_0000, 32'h1234_5000, 12'h002);
      add_req(OP_TRANSLATE, 32'h0800_0FFF, 32'h0, 12'h000);
      add_req(OP_MAP,       32'hFFFF_F000, 32'hABCD_E123, 12'h800);
      add_req(OP_TRANSLATE, 32'hFFFF_F001, 32'h0, 12'h000);
      add_req(OP_TRANSLATE, 32'hFFC0_0000, 32'h0, 12'h000);

      // random part, with the unused op code now and then
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         op_sel = $urandom_range(0, 99);
         if (op_sel < 35) op = OP_MAP;
         else if (op_sel < 55) op = OP_UNMAP;
         else if (op_sel < 95) op = OP_TRANSLATE;
         else op = 2'd3;
         add_req(op, pick_virt_addr(), $urandom, 12'($urandom_range(0, 4095)));
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // all requests taken, then all words back, then a short drain
      while (pending_reqs.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, expected_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // request driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.op          <= OP_MAP;
         req_bus.virt_addr   <= '0;
         req_bus.phys_addr   <= '0;
         req_bus.entry_flags <= '0;
         burst_left  = 1;
         idle_cycles = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            next_req.op          = req_bus.op;
            next_req.virt_addr   = req_bus.virt_addr;
            next_req.phys_addr   = req_bus.phys_addr;
            next_req.entry_flags = req_bus.entry_flags;
            expected_results.push_back(apply_page_request(next_req));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (idle_cycles > 0) begin
               idle_cycles--;
               req_bus.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               next_req = pending_reqs.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.op          <= next_req.op;
               req_bus.virt_addr   <= next_req.virt_addr;
               req_bus.phys_addr   <= next_req.phys_addr;
               req_bus.entry_flags <= next_req.entry_flags;
               if (burst_left <= 1) begin
                  burst_left  = $urandom_range(1, 24);
                  idle_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response receiver: one long hold-off, otherwise changing stall patterns
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     = 0;
         hold_done     = 1'b0;
         ready_mode    = 0;
         mode_left     = 0;
         stall_pattern = 8'hFF;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && words_received >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode    = $urandom_range(0, 3);
            mode_left     = $urandom_range(20, 200);
            stall_pattern = 8'($urandom);
         end
         mode_left--;
         case (ready_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom);
            2: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            default: begin
               stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
               rsp_bus.ready <= stall_pattern[0];
            end
         endcase
      end
   end

   // response monitor: each word against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         words_received <= 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         words_received <= words_received + 1;
         got_rsp.phys_out       = rsp_bus.phys_out;
         got_rsp.status         = rsp_bus.status;
         got_rsp.tlb_invalidate = rsp_bus.tlb_invalidate;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected word phys_out=%h status=%0d tlb_invalidate=%0d",
                     $time, got_rsp.phys_out, got_rsp.status, got_rsp.tlb_invalidate);
            error_count++;
         end else begin
            want_rsp = expected_results.pop_front();
            if (got_rsp.phys_out !== want_rsp.phys_out ||
                got_rsp.status !== want_rsp.status ||
                got_rsp.tlb_invalidate !== want_rsp.tlb_invalidate) begin
               $display("%0t: mismatch expected phys_out=%h status=%0d tlb_invalidate=%0d",
                        $time, want_rsp.phys_out, want_rsp.status, want_rsp.tlb_invalidate);
               $display("%0t:          actual   phys_out=%h status=%0d tlb_invalidate=%0d",
                        $time, got_rsp.phys_out, got_rsp.status, got_rsp.tlb_invalidate);
               error_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
